### hdl/moh_pkg.sv
`timescale 1ns / 1ps

package moh_pkg;

    localparam int VALUE_BITS = 8;
    localparam int NUM_BINS = 1 << VALUE_BITS;
    localparam int SPAN_BITS = VALUE_BITS + 1;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // control and report fields carried from the tracking stage to the bin stage
    typedef struct packed {
        t_action                       act;
        t_status                       status;
        logic signed [VALUE_BITS-1:0]  min_v;
        logic signed [VALUE_BITS-1:0]  max_v;
        logic [SPAN_BITS-1:0]          span;
        logic [VALUE_BITS-1:0]         addr;
    } t_ctl;

    // max - min + 1 over sign-extended values; fits SPAN_BITS
    function automatic logic [SPAN_BITS-1:0] span_of(
        input logic signed [VALUE_BITS-1:0] min_v,
        input logic signed [VALUE_BITS-1:0] max_v
    );
        logic [SPAN_BITS-1:0] diff;
        begin
            diff = {max_v[VALUE_BITS-1], max_v} - {min_v[VALUE_BITS-1], min_v};
            return diff + SPAN_BITS'(1);
        end
    endfunction

endpackage

### hdl/moh_track.sv
`timescale 1ns / 1ps

module moh_track import moh_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  t_action                       i_act,
    input  logic signed [VALUE_BITS-1:0]  i_sample_value,
    input  logic [VALUE_BITS-1:0]         i_bin_offset,
    output t_ctl                          o_ctl
);

    logic signed [VALUE_BITS-1:0] r_min, n_min;
    logic signed [VALUE_BITS-1:0] r_max, n_max;
    logic                         r_ne, n_ne;
    logic [SPAN_BITS-1:0]         w_span_cur;

    always_comb begin
        w_span_cur = r_ne ? span_of(r_min, r_max) : '0;
        n_min = r_min;
        n_max = r_max;
        n_ne  = r_ne;
        o_ctl.act    = i_act;
        o_ctl.status = r_ne ? ST_OK : ST_EMPTY;
        o_ctl.min_v  = r_min;
        o_ctl.max_v  = r_max;
        o_ctl.span   = w_span_cur;
        o_ctl.addr   = r_min + i_bin_offset;
        unique case (i_act)
            ACT_CLEAR: begin
                n_min = '0;
                n_max = '0;
                n_ne  = 1'b0;
                o_ctl.status = ST_EMPTY;
                o_ctl.min_v  = '0;
                o_ctl.max_v  = '0;
                o_ctl.span   = '0;
            end
            ACT_ADD: begin
                n_ne  = 1'b1;
                n_min = (!r_ne || i_sample_value < r_min) ? i_sample_value : r_min;
                n_max = (!r_ne || i_sample_value > r_max) ? i_sample_value : r_max;
                o_ctl.status = ST_OK;
                o_ctl.min_v  = n_min;
                o_ctl.max_v  = n_max;
                o_ctl.span   = span_of(n_min, n_max);
                o_ctl.addr   = i_sample_value;
            end
            ACT_READ: begin
                if (r_ne && {1'b0, i_bin_offset} >= w_span_cur) begin
                    o_ctl.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
            r_ne  <= 1'b0;
        end else if (i_adv) begin
            r_min <= n_min;
            r_max <= n_max;
            r_ne  <= n_ne;
        end
    end

endmodule

### hdl/moh_bins.sv
`timescale 1ns / 1ps

module moh_bins import moh_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  t_ctl                  i_ctl,
    input  logic                  i_wr_adv,
    output t_ctl                  o_ctl,
    output logic [COUNT_BITS-1:0] o_count
);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [NUM_BINS-1:0]   r_valid;
    t_ctl                  r_ctl;
    logic                  r_last_v;
    logic [VALUE_BITS-1:0] r_last_addr;
    logic [COUNT_BITS-1:0] r_last_cnt;
    logic [COUNT_BITS-1:0] w_base;
    logic [COUNT_BITS-1:0] w_inc;

    // read at hand-over from the tracking stage
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_ctl.addr];
            r_ctl     <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_adv && r_ctl.act == ACT_ADD) begin
            r_mem[r_ctl.addr] <= w_inc;
        end
    end

    // take the write missed by the read from the last-write register;
    // a bin not written since the last clear counts zero
    always_comb begin
        w_base = (r_last_v && r_last_addr == r_ctl.addr) ? r_last_cnt : r_rd_data;
        if (!r_valid[r_ctl.addr]) begin
            w_base = '0;
        end
        w_inc = (&w_base) ? w_base : w_base + COUNT_BITS'(1);
        unique case (r_ctl.act)
            ACT_ADD:  o_count = w_inc;
            ACT_READ: o_count = (r_ctl.status == ST_OK) ? w_base : '0;
            default:  o_count = '0;
        endcase
    end

    assign o_ctl = r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_last_v <= 1'b0;
        end else if (i_wr_adv) begin
            if (r_ctl.act == ACT_CLEAR) begin
                r_valid  <= '0;
                r_last_v <= 1'b0;
            end else if (r_ctl.act == ACT_ADD) begin
                r_valid[r_ctl.addr] <= 1'b1;
                r_last_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_adv && r_ctl.act == ACT_ADD) begin
            r_last_addr <= r_ctl.addr;
            r_last_cnt  <= w_inc;
        end
    end

endmodule

### hdl/min_offset_histogram.sv
`timescale 1ns / 1ps
// A result passes in turn through the input register, the bin read/track
// stage and the output register, each loading when the stage ahead is
// empty or moving on. Throughput: one item per cycle while the output is
// accepted; the bin read-modify-write is closed by a last-write bypass,
// so back-to-back adds to one bin need no stall.
// Reset (synchronous, active low) empties the set and all bins at once.
module min_offset_histogram import moh_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic signed [VALUE_BITS-1:0]  i_sample_value,
    input  logic [VALUE_BITS-1:0]         i_bin_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_BITS-1:0]         o_bin_count,
    output logic signed [VALUE_BITS-1:0]  o_min_value,
    output logic signed [VALUE_BITS-1:0]  o_max_value,
    output logic [SPAN_BITS-1:0]          o_bin_span,
    output logic [1:0]                    o_status
);

    // Stage one: input register, min/max tracking and bin address
    logic                         r_s1_v;
    t_action                      r_act;
    logic signed [VALUE_BITS-1:0] r_sample;
    logic [VALUE_BITS-1:0]        r_offset;
    // Stage two: bin read data, count update and bin write
    logic                         r_s2_v;
    // Output register
    logic                         r_out_v;
    logic [COUNT_BITS-1:0]        r_out_count;
    logic signed [VALUE_BITS-1:0] r_out_min;
    logic signed [VALUE_BITS-1:0] r_out_max;
    logic [SPAN_BITS-1:0]         r_out_span;
    t_status                      r_out_status;

    logic                  w_out_free, w_s2_free, w_s1_free;
    logic                  w_s1_adv, w_s2_adv;
    t_ctl                  w_s1_ctl, w_s2_ctl;
    logic [COUNT_BITS-1:0] w_count;

    // Each stage advances when the one ahead is empty or moving on, so items
    // behind a held result move into empty stages but stop behind a full one.
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s2_adv   = r_s2_v && w_out_free;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign w_s1_adv   = r_s1_v && w_s2_free;
    assign o_in_ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_v <= w_s1_adv;
            end
            if (w_out_free) begin
                r_out_v <= w_s2_adv;
            end
        end
    end

    // Hold the input payload until stage one hands it on
    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_s1_free) begin
            r_act    <= t_action'(i_action);
            r_sample <= i_sample_value;
            r_offset <= i_bin_offset;
        end
    end

    moh_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_s1_adv),
        .i_act          (r_act),
        .i_sample_value (r_sample),
        .i_bin_offset   (r_offset),
        .o_ctl          (w_s1_ctl)
    );

    moh_bins #(
        .COUNT_BITS (COUNT_BITS)
    ) u_bins (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_s1_adv),
        .i_ctl    (w_s1_ctl),
        .i_wr_adv (w_s2_adv),
        .o_ctl    (w_s2_ctl),
        .o_count  (w_count)
    );

    // Load the result register as stage two completes its transfer
    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_count  <= w_count;
            r_out_min    <= w_s2_ctl.min_v;
            r_out_max    <= w_s2_ctl.max_v;
            r_out_span   <= w_s2_ctl.span;
            r_out_status <= w_s2_ctl.status;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_bin_count = r_out_count;
    assign o_min_value = r_out_min;
    assign o_max_value = r_out_max;
    assign o_bin_span  = r_out_span;
    assign o_status    = r_out_status;

endmodule

### hdl/moh_check.sv
`timescale 1ns / 1ps

module moh_check import moh_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [1:0]                    i_action,
    input logic signed [VALUE_BITS-1:0]  i_sample_value,
    input logic [VALUE_BITS-1:0]         i_bin_offset,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [COUNT_BITS-1:0]         o_bin_count,
    input logic signed [VALUE_BITS-1:0]  o_min_value,
    input logic signed [VALUE_BITS-1:0]  o_max_value,
    input logic [SPAN_BITS-1:0]          o_bin_span,
    input logic [1:0]                    o_status
);

    logic [SPAN_BITS-1:0] w_span;

    assign w_span = span_of(o_min_value, o_max_value);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_count)
            && $stable(o_status) && $stable(o_bin_span))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_bin_count == '0
            && o_min_value == '0 && o_max_value == '0 && o_bin_span == '0)
        else $error("empty-set result carries data");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_RANGE |-> o_bin_count == '0
            && o_bin_span == w_span && o_min_value <= o_max_value)
        else $error("out-of-span result inconsistent");

    a_ok_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_bin_span == w_span
            && o_min_value <= o_max_value)
        else $error("span does not match min and max");

endmodule

bind min_offset_histogram moh_check #(.COUNT_BITS(COUNT_BITS)) u_moh_check (.*);
